// File: rtl/assert_macros.svh
// Assertion macros used by the state machine of the gesture recognizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TBGR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define TBGR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/tbgr_pkg.sv
// Package for the two-button gesture recognizer: types, codes and reset values.
package tbgr_pkg;

  // Width of the interval registers
  localparam int unsigned CFG_W = 16;
  // Default countdown width
  localparam int unsigned TIMER_WIDTH_DEF = 16;

  // Register reset values
  localparam logic [CFG_W-1:0] TAP_TICKS_RST   = 16'd250;
  localparam logic [CFG_W-1:0] PRESS_TICKS_RST = 16'd500;
  localparam logic [CFG_W-1:0] LONG_TICKS_RST  = 16'd9500;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    IDX_TAP_TICKS   = 2'd0,
    IDX_PRESS_TICKS = 2'd1,
    IDX_LONG_TICKS  = 2'd2
  } cfg_idx_e;

  // Input word kinds
  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_EVENT = 1'b1
  } kind_e;

  // Recognizer states
  typedef enum logic [3:0] {
    ST_IDLE         = 4'd0,
    ST_TRIGGERED    = 4'd1,
    ST_TAPPED       = 4'd2,
    ST_TAPPED2      = 4'd3,
    ST_PRESSED      = 4'd4,
    ST_LONG         = 4'd5,
    ST_SLID         = 4'd6,
    ST_BOTH_PRESSED = 4'd7,
    ST_BOTH_LONG    = 4'd8
  } state_e;

  // Gesture codes
  typedef enum logic [3:0] {
    G_NONE      = 4'd0,
    G_TAP       = 4'd1,
    G_DOUBLE    = 4'd2,
    G_PRESS     = 4'd3,
    G_LONG      = 4'd4,
    G_BOTH      = 4'd5,
    G_BOTH_LONG = 4'd6,
    G_SLIDE_LR  = 4'd7,
    G_SLIDE_RL  = 4'd8
  } gesture_e;

  // Both buttons held
  localparam logic [1:0] BTN_BOTH = 2'b11;
  localparam logic [1:0] BTN_NONE = 2'b00;

  // One result word
  typedef struct packed {
    gesture_e gesture;
    logic     unexpected;
  } result_t;

  // Interval registers handed to the recognizer
  typedef struct packed {
    logic [CFG_W-1:0] tap_ticks;
    logic [CFG_W-1:0] press_ticks;
    logic [CFG_W-1:0] long_ticks;
  } cfg_t;

endpackage

// File: rtl/tbgr_fsm.sv
// Gesture state machine with its one-shot countdown and stored push patterns.
`include "assert_macros.svh"

module tbgr_fsm #(
  parameter int unsigned TimerWidth = tbgr_pkg::TIMER_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,     // one word accepted this cycle
  input  tbgr_pkg::kind_e  kind_i,
  input  logic [1:0]       buttons_i,
  input  tbgr_pkg::cfg_t   cfg_i,
  output tbgr_pkg::result_t res_o
);

  localparam logic [31:0] TimerMax = 32'((64'd1 << TimerWidth) - 64'd1);

  tbgr_pkg::state_e       state_q, state_d;
  logic [TimerWidth-1:0]  count_q, count_d;
  logic                   run_q, run_d;
  logic [1:0]             first_q, first_d;
  logic [1:0]             second_q, second_d;
  logic                   timeout;

  // Interval to countdown value: zero acts as one, too large saturates
  function automatic logic [TimerWidth-1:0] load_val(input logic [tbgr_pkg::CFG_W-1:0] t);
    logic [31:0] w;
    w = 32'(t);
    if (w == 32'd0) w = 32'd1;
    if (w > TimerMax) w = TimerMax;
    return w[TimerWidth-1:0];
  endfunction

  // Tick that ends a running countdown
  assign timeout = (kind_i == tbgr_pkg::KIND_TICK) && run_q &&
                   (count_q <= TimerWidth'(1));

  // Next state, timer actions and result
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    run_d    = run_q;
    first_d  = first_q;
    second_d = second_q;
    res_o.gesture    = tbgr_pkg::G_NONE;
    res_o.unexpected = 1'b0;

    if (kind_i == tbgr_pkg::KIND_TICK) begin
      if (run_q && !timeout) begin
        count_d = count_q - TimerWidth'(1);
      end else if (timeout) begin
        count_d = '0;
        run_d   = 1'b0;
        unique case (state_q)
          tbgr_pkg::ST_TRIGGERED: begin
            state_d = tbgr_pkg::ST_PRESSED;
            count_d = load_val(cfg_i.long_ticks);
            run_d   = 1'b1;
          end
          tbgr_pkg::ST_TAPPED: begin
            state_d       = tbgr_pkg::ST_IDLE;
            res_o.gesture = tbgr_pkg::G_TAP;
          end
          tbgr_pkg::ST_PRESSED:      state_d = tbgr_pkg::ST_LONG;
          tbgr_pkg::ST_BOTH_PRESSED: state_d = tbgr_pkg::ST_BOTH_LONG;
          default:                   res_o.unexpected = 1'b1;
        endcase
      end
    end else begin
      unique case (state_q)
        tbgr_pkg::ST_TRIGGERED: begin
          second_d = buttons_i;
          run_d    = 1'b1;
          if (buttons_i != tbgr_pkg::BTN_NONE) begin
            state_d = tbgr_pkg::ST_BOTH_PRESSED;
            count_d = load_val(cfg_i.long_ticks);
          end else begin
            state_d = tbgr_pkg::ST_TAPPED;
            count_d = load_val(cfg_i.tap_ticks);
          end
        end
        tbgr_pkg::ST_TAPPED: begin
          run_d    = 1'b0;
          second_d = buttons_i;
          state_d  = (buttons_i != first_q) ? tbgr_pkg::ST_SLID : tbgr_pkg::ST_TAPPED2;
        end
        tbgr_pkg::ST_TAPPED2: begin
          state_d       = tbgr_pkg::ST_IDLE;
          run_d         = 1'b0;
          res_o.gesture = tbgr_pkg::G_DOUBLE;
        end
        tbgr_pkg::ST_PRESSED: begin
          second_d = buttons_i;
          if (buttons_i != tbgr_pkg::BTN_NONE) begin
            state_d = tbgr_pkg::ST_BOTH_PRESSED;
            count_d = load_val(cfg_i.long_ticks);
            run_d   = 1'b1;
          end else begin
            state_d       = tbgr_pkg::ST_IDLE;
            run_d         = 1'b0;
            res_o.gesture = tbgr_pkg::G_PRESS;
          end
        end
        tbgr_pkg::ST_LONG: begin
          state_d       = tbgr_pkg::ST_IDLE;
          run_d         = 1'b0;
          res_o.gesture = tbgr_pkg::G_LONG;
        end
        tbgr_pkg::ST_SLID: begin
          state_d       = tbgr_pkg::ST_IDLE;
          res_o.gesture = (first_q < second_q) ? tbgr_pkg::G_SLIDE_LR
                                               : tbgr_pkg::G_SLIDE_RL;
        end
        tbgr_pkg::ST_BOTH_PRESSED: begin
          run_d = 1'b0;
          if (buttons_i == tbgr_pkg::BTN_NONE) begin
            state_d       = tbgr_pkg::ST_IDLE;
            res_o.gesture = tbgr_pkg::G_BOTH;
          end
        end
        tbgr_pkg::ST_BOTH_LONG: begin
          if (buttons_i == tbgr_pkg::BTN_NONE) begin
            state_d       = tbgr_pkg::ST_IDLE;
            res_o.gesture = tbgr_pkg::G_BOTH_LONG;
          end
        end
        default: begin
          // idle: first push of a gesture, or a stray release
          first_d = buttons_i;
          if (buttons_i == tbgr_pkg::BTN_NONE) begin
            res_o.unexpected = 1'b1;
          end else if (buttons_i == tbgr_pkg::BTN_BOTH) begin
            state_d = tbgr_pkg::ST_BOTH_PRESSED;
            count_d = load_val(cfg_i.long_ticks);
            run_d   = 1'b1;
          end else begin
            state_d = tbgr_pkg::ST_TRIGGERED;
            count_d = load_val(cfg_i.press_ticks);
            run_d   = 1'b1;
          end
        end
      endcase
    end
  end

  // State update only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tbgr_pkg::ST_IDLE;
      count_q  <= '0;
      run_q    <= 1'b0;
      first_q  <= '0;
      second_q <= '0;
    end else if (step_i) begin
      state_q  <= state_d;
      count_q  <= count_d;
      run_q    <= run_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  // A running countdown never sits at zero
  `TBGR_ASSERT(a_run_nonzero, clk_i, rst_ni, run_q |-> (count_q != '0), "running countdown at zero")
  // Idle never has the timer running
  `TBGR_ASSERT_NEVER(a_idle_stopped, clk_i, rst_ni, (state_q == tbgr_pkg::ST_IDLE) && run_q, "timer running in idle")
  // States without a timeout keep the timer stopped
  `TBGR_ASSERT_NEVER(a_no_timer_states, clk_i, rst_ni, run_q && ((state_q == tbgr_pkg::ST_TAPPED2) || (state_q == tbgr_pkg::ST_LONG) || (state_q == tbgr_pkg::ST_SLID) || (state_q == tbgr_pkg::ST_BOTH_LONG)), "timer running in a state without timeout")
  // A tap reported on a timeout tick leaves the timer stopped in idle
  `TBGR_ASSERT(a_tap_on_tick, clk_i, rst_ni, (step_i && (res_o.gesture == tbgr_pkg::G_TAP)) |=> (!run_q && (state_q == tbgr_pkg::ST_IDLE)), "tap not followed by stopped idle")

endmodule

// File: rtl/two_button_gesture_recognizer_core.sv
// Top level of the two-button gesture recognizer: ports, registers, output stage.
//
// Input stream (s_axis): one word per timer tick or touch event. tuser carries the
// kind (0 tick, 1 push/release event), tdata carries the button status after the
// event (bit0 button A, bit1 button B); tdata is ignored for ticks.
// Output stream (m_axis): exactly one word per input word, in order. tdata carries
// the gesture code, tuser the unexpected-event flag.
// Configuration: cfg_valid_i/cfg_index_i/cfg_data_i write the tap, press and long
// intervals (index 0, 1, 2); cfg_ready_o is always high. Write only while idle.
// Output: the result of a word is on m_axis in the cycle after the word is accepted.
// Throughput: one word per cycle while m_axis_tready is high; the whole state machine and
// countdown step is combinational logic between the recognizer state and the output register.
// Stall: the output register holds its word while m_axis_tready is low, and
// s_axis_tready drops only while that register is full and not being drained.
// Reset: state idle, timer stopped, push patterns cleared, intervals back to
// 250/500/9500 ticks, output empty.
module two_button_gesture_recognizer_core #(
  parameter int unsigned TimerWidth = tbgr_pkg::TIMER_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] buttons, [7:2] zero
  input  logic [0:0]  s_axis_tuser,   // [0] kind
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] gesture, [7:4] zero
  output logic [0:0]  m_axis_tuser,   // [0] unexpected
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  tbgr_pkg::cfg_t    cfg_q;
  tbgr_pkg::result_t res;
  tbgr_pkg::result_t out_q;
  logic              out_vld_q;
  logic              accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Interval registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_ticks   <= tbgr_pkg::TAP_TICKS_RST;
      cfg_q.press_ticks <= tbgr_pkg::PRESS_TICKS_RST;
      cfg_q.long_ticks  <= tbgr_pkg::LONG_TICKS_RST;
    end else if (cfg_valid_i) begin
      unique case (tbgr_pkg::cfg_idx_e'(cfg_index_i))
        tbgr_pkg::IDX_TAP_TICKS:   cfg_q.tap_ticks   <= cfg_data_i;
        tbgr_pkg::IDX_PRESS_TICKS: cfg_q.press_ticks <= cfg_data_i;
        tbgr_pkg::IDX_LONG_TICKS:  cfg_q.long_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tbgr_fsm #(
    .TimerWidth(TimerWidth)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .kind_i    (tbgr_pkg::kind_e'(s_axis_tuser[0])),
    .buttons_i (s_axis_tdata[1:0]),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_q.gesture};
  assign m_axis_tuser  = out_q.unexpected;

endmodule
